// File: sv/hsst_pkg.sv
package hsst_pkg;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_DESTROY = 2'd2,
		OP_PURGE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam int unsigned ROT_STEP = 5;

	// one table entry as stored in memory
	typedef struct packed {
		logic [31:0] key;
		logic [15:0] handler;
		logic [7:0]  owner;
	} entry_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] d;
		d = {v, v} << s;
		return d[63:32];
	endfunction

endpackage

// File: sv/hashed_sorted_service_table_unit.sv
// channel | direction | handshake     | payload
// in      | input     | valid / stall | op, name_byte, name_last, key_in, handler_id, owner_id
// out     | output    | out_valid / out_stall | status, key_out, found_handler, found_owner,
//         |           |               | removed_count
// a name byte that is not last is taken and gives no item out.
// lookup: up to log2(TABLE_ENTRIES)+1 binary-search steps, each a read and a compare.
// create/destroy: search, then a shift of the table tail, a read and a write per entry
// (one read port, one write port); purge: a read and a write state per stored entry.
// reset clears state, count, hash, rotation and out_valid only; the memory needs no clearing pass.
// a result waits in the output register while out_stall is high; no new item
// is taken until it has gone.
module hashed_sorted_service_table_unit
	import hsst_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  op,
	input  logic [7:0]  name_byte,
	input  logic        name_last,
	input  logic [31:0] key_in,
	input  logic [15:0] handler_id,
	input  logic [7:0]  owner_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] key_out,
	output logic [15:0] found_handler,
	output logic [7:0]  found_owner,
	output logic [8:0]  removed_count
);

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SRCH   = 10'b0000000010,
		S_SWAIT  = 10'b0000000100,
		S_DECIDE = 10'b0000001000,
		S_INSRD  = 10'b0000010000,
		S_INSWR  = 10'b0000100000,
		S_DELRD  = 10'b0001000000,
		S_DELWR  = 10'b0010000000,
		S_PRD    = 10'b0100000000,
		S_PWR    = 10'b1000000000
	} state_t;

	state_t       state_q;
	logic [CW-1:0] count_q, lo_q, hi_q, idx_q, w_q;
	logic [31:0]  hash_q, key_q;
	logic [4:0]   rot_q;
	op_t          op_q;
	logic [15:0]  hnd_q;
	logic [7:0]   own_q;
	logic [8:0]   rem_q;

	// table memory, one read and one write port
	entry_t       mem [TABLE_ENTRIES];
	entry_t       rd_q;
	logic [AW-1:0] raddr, waddr;
	logic         we;
	entry_t       wdata;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	logic         accept;
	logic [31:0]  hash_nx;
	logic [CW-1:0] mid;
	assign stall   = (state_q != S_IDLE) || out_valid;
	assign accept  = valid && !stall;
	assign hash_nx = hash_q ^ rotl32({24'd0, name_byte}, rot_q);
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);

	// memory address and write control
	always_comb begin
		raddr = mid[AW-1:0];
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rd_q;
		case (state_q)
			S_INSRD: raddr = idx_q[AW-1:0] - AW'(1);
			S_INSWR: begin
				we = 1'b1;
				if (idx_q == lo_q) begin
					wdata = '{key: key_q, handler: hnd_q, owner: own_q};
				end
			end
			S_DELRD: raddr = idx_q[AW-1:0] + AW'(1);
			S_DELWR: we = 1'b1;
			S_PRD:   raddr = idx_q[AW-1:0];
			S_PWR: begin
				waddr = w_q[AW-1:0];
				we    = (rd_q.owner != own_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			hash_q    <= '0;
			rot_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= op_t'(op);
						hnd_q <= handler_id;
						own_q <= owner_id;
						status        <= ST_OK;
						found_handler <= '0;
						found_owner   <= '0;
						removed_count <= '0;
						lo_q <= '0;
						hi_q <= count_q;
						if (op == OP_CREATE || op == OP_LOOKUP) begin
							if (name_last) begin
								hash_q  <= '0;
								rot_q   <= '0;
								key_q   <= hash_nx;
								key_out <= hash_nx;
								state_q <= S_SRCH;
							end else begin
								hash_q <= hash_nx;
								rot_q  <= rot_q + 5'(ROT_STEP);
							end
						end else if (op == OP_DESTROY) begin
							key_q   <= key_in;
							key_out <= key_in;
							state_q <= S_SRCH;
						end else begin
							key_out <= '0;
							idx_q   <= '0;
							w_q     <= '0;
							rem_q   <= '0;
							state_q <= S_PRD;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_SWAIT;
					end else begin
						idx_q   <= lo_q;
						state_q <= S_DECIDE;
					end
				end
				S_SWAIT: begin
					if (rd_q.key < key_q) begin
						lo_q <= mid + CW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_DECIDE: begin
					// rd_q holds entry at lo after the final read
					logic hit;
					hit = (lo_q < count_q) && (rd_q.key == key_q);
					state_q <= S_IDLE;
					case (op_q)
						OP_CREATE: begin
							if (hit) begin
								status    <= ST_DUPLICATE;
								out_valid <= 1'b1;
							end else if (count_q >= CW'(TABLE_ENTRIES)) begin
								status    <= ST_FULL;
								out_valid <= 1'b1;
							end else begin
								idx_q   <= count_q;
								state_q <= (count_q == lo_q) ? S_INSWR : S_INSRD;
							end
						end
						OP_LOOKUP: begin
							out_valid <= 1'b1;
							if (hit) begin
								found_handler <= rd_q.handler;
								found_owner   <= rd_q.owner;
							end else begin
								status <= ST_NOT_FOUND;
							end
						end
						OP_DESTROY: begin
							if (hit) begin
								removed_count <= 9'd1;
								if (lo_q + CW'(1) < count_q) begin
									state_q <= S_DELRD;
								end else begin
									count_q   <= count_q - CW'(1);
									out_valid <= 1'b1;
								end
							end else begin
								status    <= ST_NOT_FOUND;
								out_valid <= 1'b1;
							end
						end
						default: out_valid <= 1'b1;
					endcase
				end
				S_INSRD: state_q <= S_INSWR;
				S_INSWR: begin
					if (idx_q == lo_q) begin
						count_q   <= count_q + CW'(1);
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= (idx_q - CW'(1) == lo_q) ? S_INSWR : S_INSRD;
					end
				end
				S_DELRD: state_q <= S_DELWR;
				S_DELWR: begin
					if (idx_q + CW'(2) < count_q) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_DELRD;
					end else begin
						count_q   <= count_q - CW'(1);
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_PRD: begin
					if (idx_q < count_q) begin
						state_q <= S_PWR;
					end else begin
						count_q       <= w_q;
						removed_count <= rem_q;
						out_valid     <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_PWR: begin
					if (rd_q.owner == own_q) begin
						rem_q <= rem_q + 9'd1;
					end else begin
						w_q <= w_q + CW'(1);
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_PRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
